>>> rtl/base64_stream_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the base64 stream decoder unit
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE64_STREAM_DECODER_UNIT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define B64D_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b64d: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64d: next-cycle check failed");

`else

`define B64D_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define B64D_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 decoder package
// Character constants and the alphabet lookup shared by the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

   // Padding character '='.
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Largest number of results that one item can cause.
   localparam int unsigned MAX_RESULTS = 4;

   // Result of an alphabet lookup.
   typedef struct packed {
      logic       ok;
      logic [5:0] val;
   } sextet_type;

   // Maps one character to its sextet value; ok is low outside the alphabet.
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      r.ok  = 1'b1;
      r.val = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.val = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.val = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.val = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         r.val = 6'd62;
      end else if (c == 8'h2F) begin
         r.val = 6'd63;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/base64_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder unit
// Decodes one base64 character per item and emits data bytes and a status.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one character per item; req_end_of_text marks
//   the last character of a string. The rsp_ channel carries data bytes as
//   each 4-character group completes (3, 2 or 1 bytes), and the item marked
//   end of text adds a status result with rsp_decode_ok. rsp_last_of_run
//   flags the last result that an item causes.
//   The first result of an item appears in the cycle after it is accepted,
//   and the item holds the result register until its results have left; the
//   next item is accepted in the cycle that the last of them leaves, so
//   characters that cause at most one result flow at one item per cycle
//   while the receiver does not stall.
//   When the receiver stalls, the pending results hold and req_stall stays
//   high as long as any result is held.
//   Reset clears the group state and drops any pending results. After the
//   item marked end of text the decoder returns to its reset state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_decoder_unit_macros.svh"

module base64_stream_decoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_status,
   output logic            rsp_decode_ok,
   output logic            rsp_last_of_run
);
   import b64d_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

   // Group state.
   logic [1:0]  pos_ff, pos_in;
   logic [17:0] buf_ff, buf_in;
   logic        pat_ff, pat_in;
   logic        fin_ff, fin_in;
   logic        err_ff, err_in;

   // Pending results of the last item.
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [23:0]      word_ff, word_in;
   logic             stat_ff, stat_in;
   logic             ok_ff, ok_in;

   logic             accept;
   logic             pop;
   sextet_type       sx;
   logic             is_pad;
   logic [1:0]       ndata;
   logic [23:0]      bytes;
   logic [23:0]      full_word;

   // Handshake: accept when the result register is empty or drains now.
   assign rsp_valid = (cnt_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = (cnt_ff > CNT_W'(1)) || ((cnt_ff == CNT_W'(1)) && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // Character classification.
   assign sx        = sextet_of(req_char_in);
   assign is_pad    = (req_char_in == PAD_CHAR);
   assign full_word = {buf_ff, sx.val};

   // Next group state and the bytes that the item yields.
   always_comb begin
      pos_in = pos_ff + 2'd1;
      buf_in = buf_ff;
      pat_in = pat_ff;
      fin_in = fin_ff;
      err_in = err_ff;
      ndata  = 2'd0;
      bytes  = 24'd0;
      if (!fin_ff && !err_ff) begin
         case (pos_ff)
            2'd0, 2'd1: begin
               if (pos_ff == 2'd0) begin
                  buf_in = 18'd0;
               end
               if (is_pad || !sx.ok) begin
                  err_in = 1'b1;
               end else if (pos_ff == 2'd0) begin
                  buf_in = {12'd0, sx.val};
               end else begin
                  buf_in = {buf_ff[11:0], sx.val};
               end
            end
            2'd2: begin
               if (is_pad) begin
                  pat_in = 1'b1;
               end else if (!sx.ok) begin
                  err_in = 1'b1;
               end else begin
                  buf_in = {buf_ff[11:0], sx.val};
               end
            end
            default: begin
               // Fourth character closes the group.
               if (pat_ff) begin
                  ndata  = 2'd1;
                  bytes  = {buf_ff[11:4], 16'd0};
                  fin_in = 1'b1;
               end else if (is_pad) begin
                  ndata  = 2'd2;
                  bytes  = {buf_ff[17:10], buf_ff[9:2], 8'd0};
                  fin_in = 1'b1;
               end else if (!sx.ok) begin
                  err_in = 1'b1;
               end else begin
                  ndata  = 2'd3;
                  bytes  = full_word;
               end
               pat_in = 1'b0;
               buf_in = 18'd0;
            end
         endcase
      end
      // Status result; the decoder then returns to its reset state.
      ok_in = !err_in && (pos_in == 2'd0);
      if (req_end_of_text) begin
         pos_in = 2'd0;
         buf_in = 18'd0;
         pat_in = 1'b0;
         fin_in = 1'b0;
         err_in = 1'b0;
      end
   end

   // Result register loads on accept and shifts out one byte per pop.
   always_comb begin
      cnt_in  = cnt_ff;
      word_in = word_ff;
      stat_in = stat_ff;
      if (accept) begin
         cnt_in  = CNT_W'(ndata) + CNT_W'(req_end_of_text);
         word_in = bytes;
         stat_in = req_end_of_text;
      end else if (pop) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         word_in = {word_ff[15:0], 8'd0};
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
         buf_ff <= 18'd0;
         pat_ff <= 1'b0;
         fin_ff <= 1'b0;
         err_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (accept) begin
            pos_ff <= pos_in;
            buf_ff <= buf_in;
            pat_ff <= pat_in;
            fin_ff <= fin_in;
            err_ff <= err_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      stat_ff <= stat_in;
      if (accept) begin
         ok_ff <= ok_in;
      end
   end

   // Output view of the head result.
   assign rsp_is_status   = stat_ff && (cnt_ff == CNT_W'(1));
   assign rsp_out_byte    = rsp_is_status ? 8'd0 : word_ff[23:16];
   assign rsp_decode_ok   = rsp_is_status && ok_ff;
   assign rsp_last_of_run = (cnt_ff == CNT_W'(1));

   // Checks.
   `B64D_ASSERT_SAME(a_cnt_max, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_RESULTS))
   `B64D_ASSERT_SAME(a_accept_room, clock, reset, accept, cnt_ff <= CNT_W'(1))
   `B64D_ASSERT_NEXT(a_eot_clears, clock, reset, accept && req_end_of_text,
                     pos_ff == 2'd0 && !err_ff && !fin_ff && !pat_ff)
   `B64D_ASSERT_SAME(a_status_last, clock, reset, rsp_valid && rsp_is_status,
                     rsp_last_of_run)
   `B64D_ASSERT_SAME(a_fin_err_excl, clock, reset, 1'b1, !(fin_ff && err_ff))

endmodule

`default_nettype wire
